>>> hdl/assert_macros.svh
// Assertion macros shared by the RTL files of the seven-segment command block.
// Depends on nothing; take it in with an include of the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every rising edge outside reset.
`define S7C_ASSERT(name, clock, reset, cond, msg) \
  name: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Check a consequence in the cycle after its trigger, outside reset.
`define S7C_ASSERT_NEXT(name, clock, reset, trig, cons, msg) \
  name: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/s7c_pkg.sv
// Package for the seven-segment command block: widths, segment codes, decoder.
// Depends on nothing; used by scoped names from every module of the block.
`timescale 1ns / 1ps

package s7c_pkg;

  localparam int VALUE_W   = 32;
  localparam int DIGIT_W   = 4;
  localparam int ADDR_W    = 4;
  localparam int SEG_W     = 8;

  // Reciprocal of ten: floor(x * MULT / 2^35) == x / 10 for every 32-bit x.
  localparam logic [VALUE_W-1:0] DIV10_MULT  = 32'hCCCC_CCCD;
  localparam int                 DIV10_SHIFT = 35;

  localparam logic [SEG_W-1:0] SEG_OFF   = 8'h00;
  localparam logic [SEG_W-1:0] SEG_MINUS = 8'h01;

  // Status of the queue between the front and the back.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Decimal digit to segments A..G in bits 6..0.
  function automatic logic [SEG_W-1:0] seg_decode(input logic [DIGIT_W-1:0] digit);
    logic [SEG_W-1:0] seg;
    unique case (digit)
      4'd0:    seg = 8'h7E;
      4'd1:    seg = 8'h30;
      4'd2:    seg = 8'h6D;
      4'd3:    seg = 8'h79;
      4'd4:    seg = 8'h33;
      4'd5:    seg = 8'h5B;
      4'd6:    seg = 8'h5F;
      4'd7:    seg = 8'h70;
      4'd8:    seg = 8'h7F;
      4'd9:    seg = 8'h7B;
      default: seg = SEG_OFF;
    endcase
    return seg;
  endfunction

endpackage

>>> hdl/s7c_front.sv
// Front part: takes one value, extracts its low decimal digits one per cycle, holding the last
// one while the queue is full. Depends on s7c_pkg; pushes a finished digit set into s7c_queue.
`timescale 1ns / 1ps

module s7c_front #(
  parameter int DIGITS = 8
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    push,
  output logic                                    full,
  input  logic signed [s7c_pkg::VALUE_W-1:0]      value,
  input  s7c_pkg::q_status_t                      q_status,
  output logic                                    q_push,
  output logic [DIGITS*s7c_pkg::DIGIT_W:0]        q_data
);

  localparam int CNT_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIGITS - 1);

  logic                                  busy;
  logic [CNT_W-1:0]                      cnt;
  logic [s7c_pkg::VALUE_W-1:0]           mag;
  logic                                  neg;
  logic [DIGITS-1:0][s7c_pkg::DIGIT_W-1:0] digits;

  logic [DIGITS-1:0][s7c_pkg::DIGIT_W-1:0] shifted;
  logic [2*s7c_pkg::VALUE_W-1:0]         prod;
  logic [s7c_pkg::VALUE_W-1:0]           quot;
  logic [s7c_pkg::VALUE_W-1:0]           quot10;
  logic [s7c_pkg::DIGIT_W-1:0]           rem;
  logic                                  last_step;
  logic                                  accept;

  // One digit per cycle (last held if the queue is full): divide by ten through the reciprocal.
  assign prod   = (2*s7c_pkg::VALUE_W)'(mag) * (2*s7c_pkg::VALUE_W)'(s7c_pkg::DIV10_MULT);
  assign quot   = s7c_pkg::VALUE_W'(prod >> s7c_pkg::DIV10_SHIFT);
  assign quot10 = {quot[s7c_pkg::VALUE_W-4:0], 3'b000} + {quot[s7c_pkg::VALUE_W-2:0], 1'b0};
  assign rem    = s7c_pkg::DIGIT_W'(mag - quot10);

  // The newest digit is the most significant so far; older ones move right.
  always_comb begin
    shifted[0] = rem;
    for (int i = 1; i < DIGITS; i++) begin
      shifted[i] = digits[i-1];
    end
  end

  assign last_step = (cnt == CNT_LAST);
  assign q_push    = busy && last_step && !q_status.full;
  assign q_data    = {neg, shifted};
  assign full      = busy && !q_push;
  assign accept    = push && !full;

  // Hold the count on the final step while the queue is full.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (accept) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (q_push) begin
      busy <= 1'b0;
    end else if (busy && !last_step) begin
      cnt  <= cnt + CNT_W'(1);
    end
  end

  // Payload: load the magnitude on accept, advance it and the digits on every step but the last.
  always_ff @(posedge clk) begin
    if (accept) begin
      neg <= value[s7c_pkg::VALUE_W-1];
      mag <= value[s7c_pkg::VALUE_W-1] ? (~value + 32'd1) : value;
    end else if (busy && !last_step) begin
      mag    <= quot;
      digits <= shifted;
    end
  end

endmodule

>>> hdl/s7c_queue.sv
// Two-entry queue between the front and the back of the seven-segment block.
// Depends on s7c_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module s7c_queue #(
  parameter int WIDTH = 33
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [WIDTH-1:0]   wr_data,
  input  logic               rd_en,
  output logic [WIDTH-1:0]   rd_data,
  output s7c_pkg::q_status_t status
);

  logic [1:0][WIDTH-1:0] mem;
  logic                  wr_ptr;
  logic                  rd_ptr;
  logic [1:0]            count;

  assign status.full  = (count == 2'd2);
  assign status.empty = (count == 2'd0);
  assign rd_data      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd_en) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  `S7C_ASSERT(a_q_no_overflow, clk, rst, !(wr_en && status.full), "queue written while full")
  `S7C_ASSERT(a_q_no_underflow, clk, rst, !(rd_en && status.empty), "queue read while empty")
  `S7C_ASSERT(a_q_count_range, clk, rst, count != 2'd3, "queue count out of range")

endmodule

>>> hdl/s7c_back.sv
// Back part: blanks leading zeros, places the sign, emits one command per beat.
// Depends on s7c_pkg and assert_macros.svh; reads entries from s7c_queue.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module s7c_back #(
  parameter int DIGITS = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  s7c_pkg::q_status_t                   q_status,
  input  logic [DIGITS*s7c_pkg::DIGIT_W:0]     q_data,
  output logic                                 q_pop,
  output logic                                 empty,
  input  logic                                 pop,
  output logic [s7c_pkg::ADDR_W-1:0]           digit_address,
  output logic [s7c_pkg::SEG_W-1:0]            segment_pattern,
  output logic                                 last
);

  localparam logic [s7c_pkg::ADDR_W-1:0] ADDR_FIRST = s7c_pkg::ADDR_W'(DIGITS);
  localparam logic [s7c_pkg::ADDR_W-1:0] ADDR_LAST  = s7c_pkg::ADDR_W'(1);

  logic                                      active;
  logic [s7c_pkg::ADDR_W-1:0]                addr;
  logic [DIGITS-1:0][s7c_pkg::SEG_W-1:0]     pats;

  logic                                      neg;
  logic [DIGITS-1:0][s7c_pkg::DIGIT_W-1:0]   dig;
  logic [DIGITS-1:0]                         blank;
  logic [DIGITS-1:0]                         minus;
  logic [DIGITS-1:0][s7c_pkg::SEG_W-1:0]     pats_load;
  logic                                      advance;

  assign neg = q_data[DIGITS*s7c_pkg::DIGIT_W];
  assign dig = q_data[DIGITS*s7c_pkg::DIGIT_W-1:0];

  // Leading zeros blank, the rightmost position never does.
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      if (i == DIGITS - 1) begin
        blank[i] = 1'b0;
      end else if (i == 0) begin
        blank[i] = (dig[i] == '0);
      end else begin
        blank[i] = blank[i-1] && (dig[i] == '0);
      end
    end
  end

  // Sign sits just left of the first shown digit, or on the leading one.
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      if (i == DIGITS - 1) begin
        minus[i] = neg && (i == 0);
      end else begin
        minus[i] = neg && ((blank[i] && !blank[i+1]) || (i == 0 && !blank[i]));
      end
      if (minus[i]) begin
        pats_load[i] = s7c_pkg::SEG_MINUS;
      end else if (blank[i]) begin
        pats_load[i] = s7c_pkg::SEG_OFF;
      end else begin
        pats_load[i] = s7c_pkg::seg_decode(dig[i]);
      end
    end
  end

  assign empty           = !active;
  assign digit_address   = addr;
  assign segment_pattern = pats[0];
  assign last            = (addr == ADDR_LAST);
  assign advance         = active && pop;
  assign q_pop           = !q_status.empty && (!active || (advance && last));

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      addr   <= ADDR_FIRST;
    end else if (q_pop) begin
      active <= 1'b1;
      addr   <= ADDR_FIRST;
    end else if (advance) begin
      active <= !last;
      addr   <= addr - ADDR_LAST;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      pats <= pats_load;
    end else if (advance) begin
      for (int i = 0; i < DIGITS - 1; i++) begin
        pats[i] <= pats[i+1];
      end
      pats[DIGITS-1] <= s7c_pkg::SEG_OFF;
    end
  end

  `S7C_ASSERT(a_back_addr_range, clk, rst, !active || (addr >= ADDR_LAST && addr <= ADDR_FIRST), "address out of range")
  `S7C_ASSERT_NEXT(a_back_step, clk, rst, advance && !last, active && addr == $past(addr) - ADDR_LAST, "address did not step down")

endmodule

>>> hdl/signed_int_to_seven_segment_commands.sv
// Top level of the signed integer to seven-segment command block.
// Depends on s7c_pkg, s7c_front, s7c_queue and s7c_back.
`timescale 1ns / 1ps
//
//  Channel   Handshake          Payload
//  --------  -----------------  ------------------------------------------------
//  input     push / full        value (32-bit signed)
//  result    pop / empty        digit_address (4), segment_pattern (8), last (1)
//
//  Each value yields DIGITS result beats, addresses DIGITS down to 1, last on the
//  final one. The front extracts one decimal digit per cycle through a reciprocal
//  multiplier, holding its last step while the queue is full, and accepts the next
//  value as it pushes; the back emits one beat per cycle while pop is held.
//  Reset (rst, synchronous) empties the queue and drops any value in flight.
//  A two-entry queue parts front and back: a stalled result side holds the back
//  while the front keeps accepting until the queue fills.

module signed_int_to_seven_segment_commands #(
  parameter int DIGITS = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic signed [s7c_pkg::VALUE_W-1:0] value,
  output logic                              empty,
  input  logic                              pop,
  output logic [s7c_pkg::ADDR_W-1:0]        digit_address,
  output logic [s7c_pkg::SEG_W-1:0]         segment_pattern,
  output logic                              last
);

  localparam int Q_W = DIGITS * s7c_pkg::DIGIT_W + 1;

  // Digit set plus sign flag crosses from front to back.
  logic               q_push;
  logic               q_pop;
  logic [Q_W-1:0]     q_wr_data;
  logic [Q_W-1:0]     q_rd_data;
  s7c_pkg::q_status_t q_status;

  // Front: accept a value, advance one digit per cycle, push when done and the queue has room.
  s7c_front #(
    .DIGITS (DIGITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .value    (value),
    .q_status (q_status),
    .q_push   (q_push),
    .q_data   (q_wr_data)
  );

  // Queue: hold up to two finished digit sets.
  s7c_queue #(
    .WIDTH (Q_W)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_wr_data),
    .rd_en   (q_pop),
    .rd_data (q_rd_data),
    .status  (q_status)
  );

  // Back: blank, sign, and emit one command per beat.
  s7c_back #(
    .DIGITS (DIGITS)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .q_status        (q_status),
    .q_data          (q_rd_data),
    .q_pop           (q_pop),
    .empty           (empty),
    .pop             (pop),
    .digit_address   (digit_address),
    .segment_pattern (segment_pattern),
    .last            (last)
  );

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for signed_int_to_seven_segment_commands: directed corner values and
// random values go in, and each display command beat is checked against a local prediction.
// Depends on s7c_pkg and the block's RTL only.

module tb;

  localparam int VALUE_W = s7c_pkg::VALUE_W;
  localparam int ADDR_W  = s7c_pkg::ADDR_W;
  localparam int SEG_W   = s7c_pkg::SEG_W;
  localparam logic [SEG_W-1:0] SEG_OFF   = s7c_pkg::SEG_OFF;
  localparam logic [SEG_W-1:0] SEG_MINUS = s7c_pkg::SEG_MINUS;

  localparam int NUM_DIGITS    = 8;
  localparam int CLK_PERIOD_NS = 8;
  localparam int RESET_CYCLES  = 4;
  localparam int RANDOM_ITEMS  = 310;
  localparam int IDLE_CHUNK    = 40;
  // Drain time covers the front's digit steps, the queue and the back, with a wide margin.
  localparam int DRAIN_CYCLES  = 4 * NUM_DIGITS + 16;
  // Set well above the slowest legal run, where each of the eight beats of every value
  // is stalled by the longest random gap; take that several times over.
  localparam int CYCLE_LIMIT   = 200000;
  localparam int MAX_REPORTS   = 40;

  // Segment weights, A in bit 6 down to G in bit 0.
  localparam logic [SEG_W-1:0] SEG_A = 8'h40;
  localparam logic [SEG_W-1:0] SEG_B = 8'h20;
  localparam logic [SEG_W-1:0] SEG_C = 8'h10;
  localparam logic [SEG_W-1:0] SEG_D = 8'h08;
  localparam logic [SEG_W-1:0] SEG_E = 8'h04;
  localparam logic [SEG_W-1:0] SEG_F = 8'h02;
  localparam logic [SEG_W-1:0] SEG_G = 8'h01;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [SEG_W-1:0]  pattern;
    logic              last;
  } display_cmd_t;

  // Holds the display commands still owed by the block, oldest first.
  class display_scoreboard;
    display_cmd_t pending_cmds[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    task report(string msg);
      if (errors < MAX_REPORTS) $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    // Work out the eight commands for one accepted value and queue them.
    function void note_value(logic signed [VALUE_W-1:0] v);
      logic [VALUE_W-1:0] mag;
      logic [3:0]         digit [NUM_DIGITS];
      logic [SEG_W-1:0]   pat [NUM_DIGITS];
      logic               negative;
      int                 lead;
      display_cmd_t       cmd;
      negative = v[VALUE_W-1];
      mag = v;
      if (negative) mag = ~mag + 1'b1;
      for (int i = NUM_DIGITS - 1; i >= 0; i--) begin
        digit[i] = 4'(mag % 32'd10);
        mag = mag / 32'd10;
        case (digit[i])
          4'd0:    pat[i] = SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F;
          4'd1:    pat[i] = SEG_B | SEG_C;
          4'd2:    pat[i] = SEG_A | SEG_B | SEG_D | SEG_E | SEG_G;
          4'd3:    pat[i] = SEG_A | SEG_B | SEG_C | SEG_D | SEG_G;
          4'd4:    pat[i] = SEG_B | SEG_C | SEG_F | SEG_G;
          4'd5:    pat[i] = SEG_A | SEG_C | SEG_D | SEG_F | SEG_G;
          4'd6:    pat[i] = SEG_A | SEG_C | SEG_D | SEG_E | SEG_F | SEG_G;
          4'd7:    pat[i] = SEG_A | SEG_B | SEG_C;
          4'd8:    pat[i] = SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F | SEG_G;
          default: pat[i] = SEG_A | SEG_B | SEG_C | SEG_D | SEG_F | SEG_G;
        endcase
      end
      // Blank leading zeros, always keep the rightmost digit.
      lead = 0;
      while (lead < NUM_DIGITS - 1 && digit[lead] == 4'd0) begin
        pat[lead] = SEG_OFF;
        lead++;
      end
      // Sign sits left of the first shown digit, or over it when all digits show.
      if (negative) pat[lead > 0 ? lead - 1 : 0] = SEG_MINUS;
      for (int i = 0; i < NUM_DIGITS; i++) begin
        cmd.addr    = ADDR_W'(NUM_DIGITS - i);
        cmd.pattern = pat[i];
        cmd.last    = (i == NUM_DIGITS - 1);
        pending_cmds.push_back(cmd);
      end
    endfunction

    // Compare one accepted beat with the oldest owed command.
    task check_beat(logic [ADDR_W-1:0] addr, logic [SEG_W-1:0] pattern, logic last_bit);
      display_cmd_t want;
      if (pending_cmds.size() == 0) begin
        report($sformatf("unexpected beat addr=%0d pattern=%02h last=%0b",
                         addr, pattern, last_bit));
        return;
      end
      want = pending_cmds.pop_front();
      if (addr !== want.addr)
        report($sformatf("digit_address %0d, want %0d", addr, want.addr));
      if (pattern !== want.pattern)
        report($sformatf("segment_pattern %02h, want %02h (addr %0d)",
                         pattern, want.pattern, want.addr));
      if (last_bit !== want.last)
        report($sformatf("last %0b, want %0b (addr %0d)", last_bit, want.last, want.addr));
    endtask
  endclass

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        push = 1'b0;
  logic                        full;
  logic signed [VALUE_W-1:0]   value = '0;
  logic                        empty;
  logic                        pop = 1'b0;
  logic [ADDR_W-1:0]           digit_address;
  logic [SEG_W-1:0]            segment_pattern;
  logic                        last;

  display_scoreboard board = new();
  bit                idle_on = 1'b1;   // when clear, both sides run flat out
  int unsigned       cycle_count = 0;

  signed_int_to_seven_segment_commands #(
    .DIGITS(NUM_DIGITS)
  ) dut (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .value           (value),
    .empty           (empty),
    .pop             (pop),
    .digit_address   (digit_address),
    .segment_pattern (segment_pattern),
    .last            (last)
  );

  always #(CLK_PERIOD_NS / 2) clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Push one value: idle a random number of cycles, then hold push until the beat lands.
  // Entered and left at a falling edge with push still high, so a zero gap keeps
  // push asserted without dropping it for a step.
  task automatic send_value(input logic signed [VALUE_W-1:0] v);
    int gap;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push  <= 1'b1;
    value <= v;
    do @(posedge clk); while (full);
    board.note_value(v);
    @(negedge clk);
  endtask

  // Pop one result beat: stall a random number of cycles, then hold pop until a beat lands.
  task automatic take_beat();
    int stall;
    stall = idle_on ? $urandom_range(0, 4) : 0;
    if (stall > 0) begin
      pop <= 1'b0;
      repeat (stall) @(negedge clk);
    end
    pop <= 1'b1;
    do @(posedge clk); while (empty);
    board.check_beat(digit_address, segment_pattern, last);
    @(negedge clk);
  endtask

  // Result side: drain beats for the whole run once reset is released.
  initial begin
    wait (!rst);
    @(negedge clk);
    forever take_beat();
  end

  // Hard stop if the block hangs.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("[%0t] timeout after %0d cycles", $time, cycle_count);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int unsigned              mag;
    int                       width;
    logic signed [VALUE_W-1:0] v;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed corners: zero, sign flips, digit-count edges, modulo 10^8 wrap.
    send_value(32'sd0);
    send_value(32'sd1);
    send_value(-32'sd1);
    send_value(32'sd9);
    send_value(32'sd10);
    send_value(-32'sd10);
    send_value(32'sd1234567);
    send_value(-32'sd1234567);       // sign just fits left of seven digits
    send_value(32'sd12345678);
    send_value(-32'sd12345678);      // all eight digits shown: sign overwrites the leading one
    send_value(32'sd99999999);
    send_value(32'sd100000000);      // kept digits all zero: shows a single 0
    send_value(-32'sd100000000);     // negative with kept digits all zero: shows -0
    send_value(32'sd10000000);
    send_value(-32'sd10000000);
    send_value(32'sd2147483647);
    send_value(32'h8000_0000);       // most negative: magnitude 2147483648
    send_value(-32'sd2147483647);
    send_value(32'sd5);
    send_value(-32'sd5);
    send_value(32'sh5555_5555);
    send_value(32'shAAAA_AAAA);
    send_value(32'sd87654320);
    send_value(-32'sd900000001);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // Switch idling on or off in chunks so flat-out stretches show up too.
      if (n % IDLE_CHUNK == 0) idle_on = ($urandom_range(0, 3) != 0);

      // Halfway through, hold off until every owed command has come out.
      if (n == RANDOM_ITEMS / 2) begin
        push <= 1'b0;
        do @(negedge clk); while (board.pending_cmds.size() != 0);
      end

      case ($urandom_range(0, 7))
        0, 1: v = $urandom();
        2: begin
          // Near multiples of 10^8, where the kept digits wrap.
          mag = $urandom_range(0, 21) * 100000000 + $urandom_range(0, 12);
          v = mag;
        end
        default: begin
          // Random digit count, so blanking and sign placement vary.
          width = $urandom_range(1, NUM_DIGITS);
          mag = $urandom_range(0, 10 ** width - 1);
          v = mag;
        end
      endcase
      if ($urandom_range(0, 1) == 1) v = -v;
      send_value(v);
    end

    push <= 1'b0;
    while (board.pending_cmds.size() != 0) @(negedge clk);
    // Give any stray beat time to show up.
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (board.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
